[design/calti_pkg.sv]
// Shared types, constants and state codes of the calibration table interpolator.
`default_nettype none
package calti_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int IDX_W   = 4;
  localparam int RAW_W   = 12;
  localparam int VAL_W   = 16;
  localparam int CFG_W   = 5;
  localparam int ENTRY_W = RAW_W + VAL_W;
  localparam int PROD_W  = 30;
  localparam int QUO_W   = 30;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W   = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [3:0]       SEG_MASK  = 4'hf;
  localparam logic             REG_ENTRIES_IN_USE = 1'b0;
  localparam logic             FUNC_LOAD = 1'b0;
  localparam logic             FUNC_CONV = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [RAW_W-1:0] entry_raw;
    logic [VAL_W-1:0] entry_value;
    logic [RAW_W-1:0] reading;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] calibrated;
    logic [3:0]       segment;
    logic             divide_fault;
  } out_item_t;

  typedef struct packed {
    logic     not_empty;
    in_item_t item;
  } que_head_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_TEST, S_MUL1, S_MUL2, S_DIVSET, S_DIV, S_DONE
  } bk_state_t;

endpackage
`default_nettype wire

[design/calti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module calti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

[design/calti_front.sv]
// Front end: accepts command beats into a two-entry queue.
`default_nettype none
module calti_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire calti_pkg::in_item_t in_data,
  output logic                     busy,
  input  wire logic                pop,
  output calti_pkg::que_head_t     head
);
  import calti_pkg::*;

  in_item_t   slot_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign head.not_empty = (cnt_r != 2'd0);
  assign head.item = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) begin
      slot_r[wptr_r] <= in_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("queue popped while empty");
`endif
endmodule
`default_nettype wire

[design/calti_back.sv]
// Back end: table loads, sequential segment search and serial divide.
`default_nettype none
module calti_back #(
  parameter int TABLE_DEPTH = calti_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [calti_pkg::CFG_W-1:0] entries_in_use,
  input  wire calti_pkg::que_head_t        head,
  output logic                             pop,
  output logic                             out_valid,
  output calti_pkg::out_item_t             out_data
);
  import calti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;

  bk_state_t state_r, state_nxt;
  logic [RAW_W-1:0] r_r, r_nxt, prev_raw_r, prev_raw_nxt, cur_raw_r, cur_raw_nxt;
  logic [VAL_W-1:0] prev_val_r, prev_val_nxt, cur_val_r, cur_val_nxt;
  logic [NW-1:0] n_r, n_nxt, n_clamp;
  logic [AW-1:0] i_r, i_nxt;
  logic signed [PROD_W-1:0] prod1_r, prod1_nxt, prod2_r, prod2_nxt;
  logic [QUO_W-1:0] q_r, q_nxt, quo;
  logic [RAW_W-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic we, re;
  logic [AW-1:0] waddr;
  logic [ENTRY_W-1:0] rdata;
  logic [RAW_W-1:0] rd_raw;
  logic [VAL_W-1:0] rd_val;
  logic signed [RAW_W:0] diff_a, diff_b, divisor;
  logic signed [PROD_W:0] sum;
  logic [PROD_W:0] sum_mag;
  logic [RAW_W:0] div_mag, trial;
  logic [AW+3:0] i_ext;

  assign rd_raw = rdata[ENTRY_W-1:VAL_W];
  assign rd_val = rdata[VAL_W-1:0];
  assign waddr  = AW'(head.item.entry_index);
  assign i_ext  = (AW+4)'(i_r);

  calti_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({head.item.entry_raw, head.item.entry_value}),
    .re(re), .raddr(i_r), .rdata(rdata)
  );

  always_comb begin
    if (entries_in_use == '0) begin
      n_clamp = NW'(1);
    end else if (32'(entries_in_use) > TABLE_DEPTH) begin
      n_clamp = NW'(TABLE_DEPTH);
    end else begin
      n_clamp = NW'(entries_in_use);
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r; n_nxt = n_r; i_nxt = i_r;
    prev_raw_nxt = prev_raw_r; prev_val_nxt = prev_val_r;
    cur_raw_nxt = cur_raw_r; cur_val_nxt = cur_val_r;
    prod1_nxt = prod1_r; prod2_nxt = prod2_r;
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; neg_nxt = neg_r; cnt_nxt = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    pop = 1'b0; we = 1'b0; re = 1'b0;
    diff_a = $signed({1'b0, r_r}) - $signed({1'b0, cur_raw_r});
    diff_b = $signed({1'b0, prev_raw_r}) - $signed({1'b0, r_r});
    divisor = $signed({1'b0, prev_raw_r}) - $signed({1'b0, cur_raw_r});
    sum = $signed({prod1_r[PROD_W-1], prod1_r}) + $signed({prod2_r[PROD_W-1], prod2_r});
    sum_mag = sum[PROD_W] ? PROD_W'(0) - sum : sum;
    div_mag = divisor[RAW_W] ? -divisor : divisor;
    trial = {rem_r, q_r[QUO_W-1]};
    quo = neg_r ? -q_r : q_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.not_empty) begin
          pop = 1'b1;
          if (head.item.func == FUNC_LOAD) begin
            we = (32'(head.item.entry_index) < TABLE_DEPTH);
          end else begin
            r_nxt = head.item.reading;
            n_nxt = n_clamp;
            i_nxt = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        re = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if ((NW'(i_r) + NW'(1) < n_r) && !(rd_raw < r_r)) begin
          prev_raw_nxt = rd_raw;
          prev_val_nxt = rd_val;
          i_nxt = i_r + AW'(1);
          state_nxt = S_FETCH;
        end else begin
          cur_raw_nxt = rd_raw;
          cur_val_nxt = rd_val;
          if (i_r == '0) begin
            out_nxt.calibrated = rd_val;
            out_nxt.segment = i_ext[3:0] & SEG_MASK;
            out_nxt.divide_fault = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod1_nxt = diff_a * $signed({1'b0, prev_val_r});
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod2_nxt = diff_b * $signed({1'b0, cur_val_r});
        state_nxt = S_DIVSET;
      end
      S_DIVSET: begin
        if (divisor == '0) begin
          out_nxt.calibrated = '0;
          out_nxt.segment = i_ext[3:0] & SEG_MASK;
          out_nxt.divide_fault = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          q_nxt = sum_mag[QUO_W-1:0];
          dvs_nxt = div_mag[RAW_W-1:0];
          neg_nxt = sum[PROD_W] ^ divisor[RAW_W];
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = RAW_W'(trial - {1'b0, dvs_r});
          q_nxt = {q_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[RAW_W-1:0];
          q_nxt = {q_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_nxt.calibrated = quo[VAL_W-1:0];
        out_nxt.segment = i_ext[3:0] & SEG_MASK;
        out_nxt.divide_fault = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r <= r_nxt; n_r <= n_nxt; i_r <= i_nxt;
    prev_raw_r <= prev_raw_nxt; prev_val_r <= prev_val_nxt;
    cur_raw_r <= cur_raw_nxt; cur_val_r <= cur_val_nxt;
    prod1_r <= prod1_nxt; prod2_r <= prod2_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held two cycles");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE) else $error("queue popped outside idle");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.divide_fault |-> out_r.calibrated == '0)
    else $error("divide fault with nonzero value");
`endif
endmodule
`default_nettype wire

[design/calibration_table_interpolator.sv]
// A load is popped from the queue when the back end is idle and is written to the table in
// that cycle. For a convert, each searched entry is read from the RAM (fetch) and compared
// (test); a search that stops at entry 0 gives that entry's value. One that stops at entry
// s > 0 goes through two multiply states, a divider setup (which ends with a fault on a zero
// divisor), thirty divider iterations and a result state. Throughput is set by the search
// and the divider; a two-beat queue absorbs commands, busy is high only when it is full.
// Reset is synchronous active low; the table RAM is not cleared, entries_in_use resets to 16.
`default_nettype none
module calibration_table_interpolator #(
  parameter int TABLE_DEPTH = calti_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire calti_pkg::in_item_t          in_data,
  output logic                              out_valid,
  output calti_pkg::out_item_t              out_data,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [calti_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [calti_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [calti_pkg::APB_DW-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import calti_pkg::*;

  // The single configuration register holds the number of table entries in use.
  logic [CFG_W-1:0] entries_r, entries_nxt;
  logic cfg_wr;
  que_head_t head;
  logic pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    entries_nxt = entries_r;
    if (cfg_wr && cfg_paddr[2] == REG_ENTRIES_IN_USE) begin
      entries_nxt = cfg_pwdata[CFG_W-1:0];
    end
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ENTRIES_IN_USE) begin
      cfg_prdata = APB_DW'(entries_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_RESET;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  // The front end takes command beats; the back end loads the table or converts.
  calti_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .pop(pop), .head(head)
  );

  calti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .entries_in_use(entries_r), .head(head),
    .pop(pop), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire
